// ===== src/bpa_pkg.sv =====
// ----------------------------------------------------------------------------
// bpa_pkg: bitmap page allocator shared types and constants
// Field widths, codes, register indexes and the structs passed between units.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

    localparam int PAGE_W     = 18;
    localparam int CNT_W      = 16;
    localparam int IDX_W      = 15;
    localparam int JUMP_STEPS = 17;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    localparam logic OP_ALLOC       = 1'b0;
    localparam logic OP_FREE        = 1'b1;
    localparam logic STAT_OK        = 1'b0;
    localparam logic STAT_NO_SPACE  = 1'b1;

    localparam logic [1:0] REG_BASE_PAGE    = 2'd0;
    localparam logic [1:0] REG_PAGES_IN_USE = 2'd1;
    localparam logic [1:0] REG_COUNTING     = 2'd2;

    localparam logic [CNT_W-1:0] PAGES_IN_USE_RST = 16'd32768;

    typedef struct packed {
        logic [IDX_W-1:0] base_page;
        logic [CNT_W-1:0] pages_in_use;
        logic             counting_enabled;
    } t_cfg;

    typedef struct packed {
        logic             opcode;
        logic [IDX_W-1:0] page_index;
        logic [CNT_W-1:0] page_count;
        logic [CNT_W-1:0] alignment;
        logic [CNT_W-1:0] upper_page;
    } t_item;

    typedef struct packed {
        logic             status;
        logic [IDX_W-1:0] found_page;
        logic [CNT_W-1:0] free_count;
    } t_result;

    typedef struct packed {
        logic [PAGE_W-1:0] pos;
        logic [PAGE_W-1:0] run_end;
        logic              set;
    } t_word_req;

    typedef struct packed {
        logic              hit;
        logic              last;
        logic [PAGE_W-1:0] bad_page;
        logic [PAGE_W-1:0] next_page;
    } t_word_res;

endpackage

`default_nettype wire

// ===== src/bpa_ifs.sv =====
// ----------------------------------------------------------------------------
// bpa_ifs: request and response channels of the bitmap page allocator
// Valid/ready channels carrying one item per transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface bpa_req_if;
    logic                        valid;
    logic                        ready;
    logic                        opcode;
    logic [bpa_pkg::IDX_W-1:0]   page_index;
    logic [bpa_pkg::CNT_W-1:0]   page_count;
    logic [bpa_pkg::CNT_W-1:0]   alignment;
    logic [bpa_pkg::CNT_W-1:0]   upper_page;

    modport source (
        output valid, opcode, page_index, page_count, alignment, upper_page,
        input  ready
    );
    modport sink (
        input  valid, opcode, page_index, page_count, alignment, upper_page,
        output ready
    );
endinterface

interface bpa_rsp_if;
    logic                        valid;
    logic                        ready;
    logic                        status;
    logic [bpa_pkg::IDX_W-1:0]   found_page;
    logic [bpa_pkg::CNT_W-1:0]   free_count;

    modport source (
        output valid, status, found_page, free_count,
        input  ready
    );
    modport sink (
        input  valid, status, found_page, free_count,
        output ready
    );
endinterface

`default_nettype wire

// ===== src/bitmap_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_page_allocator_core: first-fit bitmap page allocator
// Allocates and releases runs of pages in a one-bit-per-page bitmap held in
// a single-port-read, single-port-write memory, and keeps a free page count.
//
//   channel   direction  handshake             contents
//   i_req     in         valid/ready           opcode, page_index, page_count,
//                                              alignment, upper_page
//   o_rsp     out        valid/ready           status, found_page, free_count
//   apb       in         psel/penable/pready   base_page, pages_in_use,
//                                              counting_enabled
//
// One item at a time, bounded by the bitmap memory port (one word per access).
// Allocate: test the candidate, read and check each word of the run, step past
// a used page, then read and write each word to mark. Free: read and write each
// word released; a zero-length free goes straight to the done state.
// After reset a clearing pass writes every bitmap word to all used, with
// i_req.ready low. A result waiting in the output register holds off the next transfer.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_page_allocator_core #(
    parameter int NUM_PAGES = 32768,
    parameter int WORD_BITS = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    bpa_req_if.sink                             i_req,
    bpa_rsp_if.source                           o_rsp,
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [bpa_pkg::ADDR_W-1:0]     paddr,
    input  wire logic [bpa_pkg::DATA_W-1:0]     pwdata,
    output logic      [bpa_pkg::DATA_W-1:0]     prdata,
    output logic                                pready
);

    localparam int MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int IW        = bpa_pkg::IDX_W;
    localparam int CW        = bpa_pkg::CNT_W;
    localparam int DW        = bpa_pkg::DATA_W;

    logic [IW-1:0]       r_base_page;
    logic [CW-1:0]       r_pages_in_use;
    logic                r_counting;
    logic                r_rsp_valid;
    bpa_pkg::t_result    r_rsp;

    bpa_pkg::t_cfg       cfg;
    bpa_pkg::t_item      item;
    bpa_pkg::t_result    res;
    logic                res_valid;
    logic                res_free;
    logic                item_ready;
    logic                cfg_wr;

    logic                mem_we;
    logic [AW-1:0]       mem_waddr;
    logic [AW-1:0]       mem_raddr;
    logic [WORD_BITS-1:0] mem_wdata;
    logic [WORD_BITS-1:0] mem_rdata;

    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_page    <= '0;
            r_pages_in_use <= bpa_pkg::PAGES_IN_USE_RST;
            r_counting     <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                bpa_pkg::REG_BASE_PAGE:    r_base_page    <= pwdata[IW-1:0];
                bpa_pkg::REG_PAGES_IN_USE: r_pages_in_use <= pwdata[CW-1:0];
                bpa_pkg::REG_COUNTING:     r_counting     <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            bpa_pkg::REG_BASE_PAGE:    prdata = DW'(r_base_page);
            bpa_pkg::REG_PAGES_IN_USE: prdata = DW'(r_pages_in_use);
            bpa_pkg::REG_COUNTING:     prdata = DW'(r_counting);
            default:                   prdata = '0;
        endcase
    end

    assign cfg.base_page        = r_base_page;
    assign cfg.pages_in_use     = r_pages_in_use;
    assign cfg.counting_enabled = r_counting;

    assign item.opcode     = i_req.opcode;
    assign item.page_index = i_req.page_index;
    assign item.page_count = i_req.page_count;
    assign item.alignment  = i_req.alignment;
    assign item.upper_page = i_req.upper_page;
    assign i_req.ready     = item_ready;

    assign res_free = !r_rsp_valid || o_rsp.ready;

    bpa_engine #(
        .NUM_PAGES (NUM_PAGES),
        .WORD_BITS (WORD_BITS)
    ) u_engine (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (cfg),
        .i_item_valid (i_req.valid),
        .o_item_ready (item_ready),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .i_res_free   (res_free),
        .o_res        (res),
        .o_mem_we     (mem_we),
        .o_mem_waddr  (mem_waddr),
        .o_mem_wdata  (mem_wdata),
        .o_mem_raddr  (mem_raddr),
        .i_mem_rdata  (mem_rdata)
    );

    bpa_map_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (MAP_WORDS)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (res_valid) begin
            r_rsp <= res;
        end
        if (!i_rst_n) begin
            r_rsp_valid <= 1'b0;
        end else if (res_valid) begin
            r_rsp_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_rsp_valid <= 1'b0;
        end
    end

    assign o_rsp.valid      = r_rsp_valid;
    assign o_rsp.status     = r_rsp.status;
    assign o_rsp.found_page = r_rsp.found_page;
    assign o_rsp.free_count = r_rsp.free_count;

    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while previous item in flight");

    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> (!i_req.ready && !o_rsp.valid))
        else $error("request or response active during bitmap clear");

    a_fail_no_page: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && (o_rsp.status == bpa_pkg::STAT_NO_SPACE)) |->
        (o_rsp.found_page == '0))
        else $error("failed allocation reports a page");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (32'(o_rsp.free_count) <= 32'(NUM_PAGES)))
        else $error("free page count above page total");

endmodule

`default_nettype wire

// ===== src/bpa_map_ram.sv =====
// ----------------------------------------------------------------------------
// bpa_map_ram: page bitmap storage
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_map_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 512
) (
    input  wire logic                                     i_clk,
    input  wire logic                                     i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                         i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== src/bpa_word_unit.sv =====
// ----------------------------------------------------------------------------
// bpa_word_unit: bitmap word evaluation
// Builds the run mask within one word, finds the lowest used page in it and
// forms the updated word for a mark or a release.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_word_unit #(
    parameter int NUM_PAGES = 32768,
    parameter int WORD_BITS = 64
) (
    input  wire bpa_pkg::t_word_req       i_req,
    input  wire logic [WORD_BITS-1:0]     i_data,
    output logic      [WORD_BITS-1:0]     o_data,
    output bpa_pkg::t_word_res            o_res
);

    localparam int          WB_LG = $clog2(WORD_BITS);
    localparam int          OW    = WB_LG + 1;
    localparam int          PW    = bpa_pkg::PAGE_W;
    localparam logic [31:0] NP    = 32'(NUM_PAGES);

    logic [PW-1:0]        base;
    logic [PW:0]          nxt;
    logic [OW-1:0]        lo_off;
    logic [OW-1:0]        hi_off;
    logic [OW-1:0]        lim_off;
    logic [OW-1:0]        top_off;
    logic [WORD_BITS-1:0] mask;
    logic [WORD_BITS-1:0] hits;
    logic [WB_LG-1:0]     first;

    always_comb begin
        base    = {i_req.pos[PW-1:WB_LG], {WB_LG{1'b0}}};
        nxt     = (PW+1)'(base) + (PW+1)'(WORD_BITS);
        lo_off  = OW'(i_req.pos[WB_LG-1:0]);
        hi_off  = ((PW+1)'(i_req.run_end) >= nxt) ? OW'(WORD_BITS)
                                                  : OW'(i_req.run_end - base);
        lim_off = (32'(nxt) <= NP) ? OW'(WORD_BITS) : OW'(NP - 32'(base));
        top_off = (hi_off < lim_off) ? hi_off : lim_off;

        for (int b = 0; b < WORD_BITS; b++) begin
            mask[b] = (OW'(b) >= lo_off) && (OW'(b) < top_off);
        end
        hits = i_data & mask;

        first = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (hits[b]) begin
                first = WB_LG'(b);
            end
        end

        o_data          = i_req.set ? (i_data | mask) : (i_data & ~mask);
        o_res.hit       = |hits;
        o_res.bad_page  = base + PW'(first);
        o_res.last      = ((PW+1)'(i_req.run_end) <= nxt) || (32'(nxt) >= NP);
        o_res.next_page = PW'(nxt);
    end

endmodule

`default_nettype wire

// ===== src/bpa_engine.sv =====
// ----------------------------------------------------------------------------
// bpa_engine: allocator sequencer
// Clears the bitmap after reset, scans for a first-fit run word by word,
// skips past used pages with a shift-and-add step unit, then marks or
// releases the run by read-modify-write and updates the free page counter.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_engine #(
    parameter int NUM_PAGES = 32768,
    parameter int WORD_BITS = 64
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire bpa_pkg::t_cfg              i_cfg,
    input  wire logic                       i_item_valid,
    output logic                            o_item_ready,
    input  wire bpa_pkg::t_item             i_item,
    output logic                            o_res_valid,
    input  wire logic                       i_res_free,
    output bpa_pkg::t_result                o_res,
    output logic                            o_mem_we,
    output logic [((((NUM_PAGES + WORD_BITS - 1) / WORD_BITS) > 1) ?
                   $clog2((NUM_PAGES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] o_mem_waddr,
    output logic [WORD_BITS-1:0]            o_mem_wdata,
    output logic [((((NUM_PAGES + WORD_BITS - 1) / WORD_BITS) > 1) ?
                   $clog2((NUM_PAGES + WORD_BITS - 1) / WORD_BITS) : 1)-1:0] o_mem_raddr,
    input  wire logic [WORD_BITS-1:0]       i_mem_rdata
);

    localparam int          WB_LG     = $clog2(WORD_BITS);
    localparam int          MAP_WORDS = (NUM_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int          AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int          PW        = bpa_pkg::PAGE_W;
    localparam int          CW        = bpa_pkg::CNT_W;
    localparam int          IW        = bpa_pkg::IDX_W;
    localparam int          JW        = PW + bpa_pkg::JUMP_STEPS;
    localparam logic [31:0] NP        = 32'(NUM_PAGES);
    localparam logic [4:0]  K_MAX     = 5'(bpa_pkg::JUMP_STEPS - 1);

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TEST,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_JUMP,
        ST_MARK_RD,
        ST_MARK_WR,
        ST_DONE
    } t_state;

    t_state         r_state,    n_state;
    logic [AW-1:0]  r_clr_addr, n_clr_addr;
    logic [CW-1:0]  r_free,     n_free;
    logic           r_op,       n_op;
    logic [PW-1:0]  r_cand,     n_cand;
    logic [PW-1:0]  r_pos,      n_pos;
    logic [PW-1:0]  r_run_end,  n_run_end;
    logic [CW-1:0]  r_count,    n_count;
    logic [CW-1:0]  r_align,    n_align;
    logic [CW-1:0]  r_limit,    n_limit;
    logic [PW-1:0]  r_bad,      n_bad;
    logic [PW-1:0]  r_acc,      n_acc;
    logic [4:0]     r_k,        n_k;
    logic           r_status,   n_status;
    logic [IW-1:0]  r_found,    n_found;

    bpa_pkg::t_word_req   wu_req;
    bpa_pkg::t_word_res   wu_res;
    logic [WORD_BITS-1:0] wu_data;

    logic [CW-1:0]  total;
    logic [CW-1:0]  lim_in;
    logic [PW:0]    test_end;
    logic           fits;
    logic [JW-1:0]  step;
    logic [JW-1:0]  trial;
    logic [PW-1:0]  acc_n;
    logic [CW:0]    free_sum;
    logic [CW-1:0]  free_new;
    logic [AW-1:0]  word_addr;

    assign wu_req.pos     = r_pos;
    assign wu_req.run_end = r_run_end;
    assign wu_req.set     = (r_op == bpa_pkg::OP_ALLOC);

    bpa_word_unit #(
        .NUM_PAGES (NUM_PAGES),
        .WORD_BITS (WORD_BITS)
    ) u_word (
        .i_req  (wu_req),
        .i_data (i_mem_rdata),
        .o_data (wu_data),
        .o_res  (wu_res)
    );

    always_comb begin
        total     = (32'(i_cfg.pages_in_use) < NP) ? i_cfg.pages_in_use : CW'(NUM_PAGES);
        lim_in    = ((i_item.upper_page != '0) && (i_item.upper_page < total))
                    ? i_item.upper_page : total;
        test_end  = (PW+1)'(r_cand) + (PW+1)'(r_count);
        fits      = (r_cand < PW'(r_limit)) && (test_end <= (PW+1)'(r_limit));
        step      = JW'(r_align) << r_k;
        trial     = JW'(r_acc) + step;
        acc_n     = (trial <= JW'(r_bad)) ? PW'(trial) : r_acc;
        free_sum  = (CW+1)'(r_free) + (CW+1)'(r_count);
        word_addr = AW'(r_pos >> WB_LG);

        if (r_op == bpa_pkg::OP_FREE) begin
            free_new = (free_sum > (CW+1)'(total)) ? total : CW'(free_sum);
        end else if ((r_status == bpa_pkg::STAT_OK) && i_cfg.counting_enabled) begin
            free_new = (r_free < r_count) ? '0 : (r_free - r_count);
        end else begin
            free_new = r_free;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_clr_addr = r_clr_addr;
        n_free     = r_free;
        n_op       = r_op;
        n_cand     = r_cand;
        n_pos      = r_pos;
        n_run_end  = r_run_end;
        n_count    = r_count;
        n_align    = r_align;
        n_limit    = r_limit;
        n_bad      = r_bad;
        n_acc      = r_acc;
        n_k        = r_k;
        n_status   = r_status;
        n_found    = r_found;
        o_mem_we    = 1'b0;
        o_mem_waddr = word_addr;
        o_mem_wdata = wu_data;
        o_mem_raddr = word_addr;

        case (r_state)
            ST_CLEAR: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_clr_addr;
                o_mem_wdata = '1;
                n_clr_addr  = r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(MAP_WORDS - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (i_item_valid) begin
                    n_op      = i_item.opcode;
                    n_count   = i_item.page_count;
                    n_align   = (i_item.alignment == '0) ? CW'(1) : i_item.alignment;
                    n_limit   = lim_in;
                    n_cand    = PW'(i_cfg.base_page);
                    n_pos     = PW'(i_item.page_index);
                    n_run_end = PW'(i_item.page_index) + PW'(i_item.page_count);
                    n_status  = bpa_pkg::STAT_OK;
                    n_found   = '0;
                    if (i_item.opcode == bpa_pkg::OP_FREE) begin
                        if ((i_item.page_count != '0) && (32'(i_item.page_index) < NP)) begin
                            n_state = ST_MARK_RD;
                        end else begin
                            n_state = ST_DONE;
                        end
                    end else begin
                        n_state = ST_TEST;
                    end
                end
            end
            ST_TEST: begin
                if (!fits) begin
                    n_status = bpa_pkg::STAT_NO_SPACE;
                    n_state  = ST_DONE;
                end else if (r_count == '0) begin
                    n_found = IW'(r_cand);
                    n_state = ST_DONE;
                end else begin
                    n_pos     = r_cand;
                    n_run_end = PW'(test_end);
                    n_state   = ST_SCAN_RD;
                end
            end
            ST_SCAN_RD: begin
                n_state = ST_SCAN_CHK;
            end
            ST_SCAN_CHK: begin
                if (wu_res.hit) begin
                    n_bad   = wu_res.bad_page;
                    n_acc   = r_cand;
                    n_k     = K_MAX;
                    n_state = ST_JUMP;
                end else if (wu_res.last) begin
                    n_found = IW'(r_cand);
                    n_pos   = r_cand;
                    n_state = ST_MARK_RD;
                end else begin
                    n_pos   = wu_res.next_page;
                    n_state = ST_SCAN_RD;
                end
            end
            ST_JUMP: begin
                n_acc = acc_n;
                if (r_k == '0) begin
                    n_cand  = acc_n + PW'(r_align);
                    n_state = ST_TEST;
                end else begin
                    n_k = r_k - 5'd1;
                end
            end
            ST_MARK_RD: begin
                n_state = ST_MARK_WR;
            end
            ST_MARK_WR: begin
                o_mem_we = 1'b1;
                if (wu_res.last) begin
                    n_state = ST_DONE;
                end else begin
                    n_pos   = wu_res.next_page;
                    n_state = ST_MARK_RD;
                end
            end
            ST_DONE: begin
                if (i_res_free) begin
                    n_free  = free_new;
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_item_ready    = (r_state == ST_IDLE);
    assign o_res_valid     = (r_state == ST_DONE) && i_res_free;
    assign o_res.status     = r_status;
    assign o_res.found_page = r_found;
    assign o_res.free_count = free_new;

    always_ff @(posedge i_clk) begin
        r_op      <= n_op;
        r_cand    <= n_cand;
        r_pos     <= n_pos;
        r_run_end <= n_run_end;
        r_count   <= n_count;
        r_align   <= n_align;
        r_limit   <= n_limit;
        r_bad     <= n_bad;
        r_acc     <= n_acc;
        r_k       <= n_k;
        r_status  <= n_status;
        r_found   <= n_found;
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
            r_free     <= '0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_free     <= n_free;
        end
    end

endmodule

`default_nettype wire

// ===== test/tb_bitmap_page_allocator_core.sv =====
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_core: self-checking bench for the page allocator
// Drives allocate and free transfers, with random gaps in most phases, on the
// request and response channels. Each accepted request is run through a
// bit-level model of the page bitmap and free counter. Each response is
// checked against the oldest predicted result. Register settings change
// between phases, only while the block is idle. The phases take in an empty
// page span, a saturated counter, a top base page and a clamped page total.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_bitmap_page_allocator_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_PG      = 32768;
    localparam int QUIET_LIMIT = 100000;
    localparam int MAX_REPORTS = 10;
    localparam logic [1:0] REG_SPARE = 2'd3;

    logic                         i_clk   = 1'b0;
    logic                         i_rst_n = 1'b0;
    logic                         psel    = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite  = 1'b0;
    logic [bpa_pkg::ADDR_W-1:0]   paddr   = '0;
    logic [bpa_pkg::DATA_W-1:0]   pwdata  = '0;
    logic [bpa_pkg::DATA_W-1:0]   prdata;
    logic                         pready;

    bpa_req_if req_if ();
    bpa_rsp_if rsp_if ();

    bitmap_page_allocator_core uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    bit                        page_map [NUM_PG];
    int unsigned               spare_pages;
    logic [bpa_pkg::IDX_W-1:0] base_cfg;
    logic [bpa_pkg::CNT_W-1:0] pages_cfg;
    logic                      count_cfg;

    bpa_pkg::t_item   req_backlog [$];
    bpa_pkg::t_result due_results [$];
    int unsigned fault_count  = 0;
    int unsigned quiet_cycles = 0;
    int unsigned src_gap      = 0;
    int unsigned snk_gap      = 0;
    bit          idle_on      = 1'b1;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int unsigned span_pages();
        return (pages_cfg > NUM_PG) ? NUM_PG : pages_cfg;
    endfunction

    function automatic bpa_pkg::t_result apply_page_op(input bpa_pkg::t_item it);
        bpa_pkg::t_result res;
        int unsigned      total;
        int unsigned      limit;
        int unsigned      idx;
        int unsigned      step;
        int unsigned      bad;
        int unsigned      n;
        bit               found;
        bit               clash;
        total = span_pages();
        res   = '0;
        if (it.opcode == bpa_pkg::OP_FREE) begin
            for (n = 0; n < it.page_count; n++) begin
                if (it.page_index + n < NUM_PG) page_map[it.page_index + n] = 1'b0;
            end
            spare_pages = (spare_pages + it.page_count > total) ? total
                                                               : spare_pages + it.page_count;
        end else begin
            limit = total;
            idx   = base_cfg;
            step  = (it.alignment == 0) ? 1 : it.alignment;
            found = 1'b0;
            bad   = 0;
            if (it.upper_page != 0 && it.upper_page < limit) limit = it.upper_page;
            while (!found && idx < limit && idx + it.page_count <= limit) begin
                clash = 1'b0;
                for (n = 0; n < it.page_count && !clash; n++) begin
                    if (page_map[idx + n]) begin
                        clash = 1'b1;
                        bad   = idx + n;
                    end
                end
                if (clash) idx += ((bad + 1 - idx + step - 1) / step) * step;
                else found = 1'b1;
            end
            if (found) begin
                for (n = 0; n < it.page_count; n++) page_map[idx + n] = 1'b1;
                if (count_cfg)
                    spare_pages = (spare_pages < it.page_count) ? 0
                                                                : spare_pages - it.page_count;
                res.found_page = idx[bpa_pkg::IDX_W-1:0];
            end else begin
                res.status = bpa_pkg::STAT_NO_SPACE;
            end
        end
        res.free_count = spare_pages[bpa_pkg::CNT_W-1:0];
        return res;
    endfunction

    function automatic bpa_pkg::t_item gen_page_op(input int unsigned span);
        bpa_pkg::t_item it;
        int unsigned    top;
        top = (span > 0) ? span : 1;
        it.opcode = ($urandom_range(0, 1) == 0) ? bpa_pkg::OP_ALLOC : bpa_pkg::OP_FREE;
        it.page_index = ($urandom_range(0, 7) == 0)
                        ? bpa_pkg::IDX_W'($urandom)
                        : bpa_pkg::IDX_W'($urandom_range(0, top - 1));
        case ($urandom_range(0, 31))
            0: it.page_count = '0;
            1: it.page_count = bpa_pkg::CNT_W'($urandom);
            2, 3: it.page_count = bpa_pkg::CNT_W'($urandom_range(1, top));
            default: it.page_count = bpa_pkg::CNT_W'($urandom_range(1, 16));
        endcase
        case ($urandom_range(0, 15))
            0: it.alignment = '0;
            1: it.alignment = bpa_pkg::CNT_W'($urandom);
            2, 3, 4, 5: it.alignment = bpa_pkg::CNT_W'(1 << $urandom_range(0, 6));
            default: it.alignment = bpa_pkg::CNT_W'(1);
        endcase
        case ($urandom_range(0, 7))
            0: it.upper_page = bpa_pkg::CNT_W'($urandom);
            1, 2: it.upper_page = bpa_pkg::CNT_W'($urandom_range(1, top + 1));
            default: it.upper_page = '0;
        endcase
        return it;
    endfunction

    function automatic void queue_op(input logic op,
                                     input logic [bpa_pkg::IDX_W-1:0] pidx,
                                     input logic [bpa_pkg::CNT_W-1:0] cnt,
                                     input logic [bpa_pkg::CNT_W-1:0] aln,
                                     input logic [bpa_pkg::CNT_W-1:0] upr);
        bpa_pkg::t_item it;
        it = {op, pidx, cnt, aln, upr};
        req_backlog.push_back(it);
    endfunction

    function automatic void queue_random(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) req_backlog.push_back(gen_page_op(span_pages()));
    endfunction

    task automatic note_fault(input string what, input bpa_pkg::t_result want,
                              input bpa_pkg::t_result got);
        fault_count++;
        if (fault_count <= MAX_REPORTS)
            $display("%0t %s: expected status %0d page %0d free %0d, got status %0d page %0d free %0d",
                     $time, what, want.status, want.found_page, want.free_count,
                     got.status, got.found_page, got.free_count);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [bpa_pkg::DATA_W-1:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            bpa_pkg::REG_BASE_PAGE:    base_cfg  = val[bpa_pkg::IDX_W-1:0];
            bpa_pkg::REG_PAGES_IN_USE: pages_cfg = val[bpa_pkg::CNT_W-1:0];
            bpa_pkg::REG_COUNTING:     count_cfg = val[0];
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (req_backlog.size() != 0 || req_if.valid || due_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    // request driver
    always @(posedge i_clk) begin
        bpa_pkg::t_item nxt;
        if (!i_rst_n) begin
            req_if.valid      <= 1'b0;
            req_if.opcode     <= bpa_pkg::OP_ALLOC;
            req_if.page_index <= '0;
            req_if.page_count <= '0;
            req_if.alignment  <= '0;
            req_if.upper_page <= '0;
            src_gap           <= 0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                nxt = {req_if.opcode, req_if.page_index, req_if.page_count,
                       req_if.alignment, req_if.upper_page};
                due_results.push_back(apply_page_op(nxt));
            end
            if (!req_if.valid || req_if.ready) begin
                if (src_gap != 0) begin
                    src_gap      <= src_gap - 1;
                    req_if.valid <= 1'b0;
                end else if (idle_on && $urandom_range(0, 7) == 0) begin
                    src_gap      <= $urandom_range(0, 15);
                    req_if.valid <= 1'b0;
                end else if (req_backlog.size() != 0) begin
                    nxt = req_backlog.pop_front();
                    req_if.opcode     <= nxt.opcode;
                    req_if.page_index <= nxt.page_index;
                    req_if.page_count <= nxt.page_count;
                    req_if.alignment  <= nxt.alignment;
                    req_if.upper_page <= nxt.upper_page;
                    req_if.valid      <= 1'b1;
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        bpa_pkg::t_result got;
        bpa_pkg::t_result want;
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
            snk_gap      <= 0;
        end else begin
            if (rsp_if.valid && rsp_if.ready) begin
                got = {rsp_if.status, rsp_if.found_page, rsp_if.free_count};
                if (due_results.size() == 0) begin
                    note_fault("response with nothing pending", '0, got);
                end else begin
                    want = due_results.pop_front();
                    if (got.status !== want.status || got.found_page !== want.found_page ||
                        got.free_count !== want.free_count)
                        note_fault("response mismatch", want, got);
                end
            end
            if (snk_gap != 0) begin
                snk_gap      <= snk_gap - 1;
                rsp_if.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 7) == 0) begin
                snk_gap      <= $urandom_range(0, 15);
                rsp_if.ready <= 1'b0;
            end else begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(negedge i_clk);
        $display("FAIL bitmap_page_allocator_core");
        $finish;
    end

    initial begin
        foreach (page_map[p]) page_map[p] = 1'b1;
        spare_pages = 0;
        base_cfg    = '0;
        pages_cfg   = bpa_pkg::PAGES_IN_USE_RST;
        count_cfg   = 1'b1;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: every page used, counter at zero
        queue_op(bpa_pkg::OP_ALLOC, 0, 1, 1, 64);
        queue_op(bpa_pkg::OP_FREE, 0, 16'h8000, 1, 0);
        queue_op(bpa_pkg::OP_FREE, 15'h7FFF, 16'h8000, 1, 0);
        queue_op(bpa_pkg::OP_ALLOC, 15'h7FFF, 16'h8000, 1, 0);
        queue_op(bpa_pkg::OP_FREE, 100, 0, 1, 0);
        queue_op(bpa_pkg::OP_FREE, 16, 8, 1, 0);
        queue_op(bpa_pkg::OP_ALLOC, 0, 0, 0, 0);
        queue_op(bpa_pkg::OP_ALLOC, 0, 4, 0, 0);
        queue_op(bpa_pkg::OP_ALLOC, 0, 4, 8, 32);
        queue_op(bpa_pkg::OP_ALLOC, 0, 4, 4, 0);
        queue_op(bpa_pkg::OP_FREE, 40, 16, 1, 0);
        queue_op(bpa_pkg::OP_ALLOC, 0, 8, 2, 44);
        queue_op(bpa_pkg::OP_ALLOC, 0, 16'hFFFF, 1, 0);
        queue_op(bpa_pkg::OP_ALLOC, 0, 16, 16'h8000, 0);
        queue_op(bpa_pkg::OP_ALLOC, 0, 16, 16'hFFFF, 0);
        queue_op(bpa_pkg::OP_ALLOC, 0, 8, 8, 0);
        queue_op(bpa_pkg::OP_FREE, 15'h7FFF, 1, 1, 0);
        queue_op(bpa_pkg::OP_ALLOC, 0, 1, 1, 16'hFFFF);
        queue_op(bpa_pkg::OP_FREE, 15'h7FF0, 16'hFFFF, 1, 0);
        queue_op(bpa_pkg::OP_ALLOC, 0, 2, 3, 60);
        queue_op(bpa_pkg::OP_ALLOC, 0, 3, 1, 16'h8000);
        settle();

        write_reg(bpa_pkg::REG_BASE_PAGE, 0);
        write_reg(bpa_pkg::REG_PAGES_IN_USE, 512);
        write_reg(bpa_pkg::REG_COUNTING, 1);
        write_reg(REG_SPARE, $urandom);
        queue_op(bpa_pkg::OP_FREE, 0, 512, 1, 0);
        queue_random(170);
        settle();

        write_reg(bpa_pkg::REG_BASE_PAGE, 100);
        write_reg(bpa_pkg::REG_PAGES_IN_USE, 256);
        write_reg(bpa_pkg::REG_COUNTING, 0);
        queue_op(bpa_pkg::OP_FREE, 0, 256, 1, 0);
        queue_random(120);
        settle();

        idle_on = 1'b0;
        write_reg(bpa_pkg::REG_PAGES_IN_USE, 0);
        queue_random(20);
        settle();

        idle_on = 1'b1;
        write_reg(bpa_pkg::REG_BASE_PAGE, 15'h7FFF);
        write_reg(bpa_pkg::REG_PAGES_IN_USE, 16'hFFFF);
        write_reg(bpa_pkg::REG_COUNTING, 1);
        queue_op(bpa_pkg::OP_ALLOC, 0, 1, 1, 0);
        queue_random(40);
        settle();

        // last stretch runs without gaps
        idle_on = 1'b0;
        write_reg(bpa_pkg::REG_BASE_PAGE, 7);
        write_reg(bpa_pkg::REG_PAGES_IN_USE, 128);
        queue_op(bpa_pkg::OP_FREE, 0, 128, 1, 0);
        queue_random(130);
        settle();

        repeat (20) @(posedge i_clk);
        fault_count += due_results.size();
        if (fault_count == 0)
            $display("PASS bitmap_page_allocator_core");
        else
            $display("FAIL bitmap_page_allocator_core");
        $finish;
    end

endmodule

`default_nettype wire

// ===== bitmap_page_allocator_core.f =====
src/bpa_pkg.sv
src/bpa_ifs.sv
src/bpa_map_ram.sv
src/bpa_word_unit.sv
src/bpa_engine.sv
src/bitmap_page_allocator_core.sv
test/tb_bitmap_page_allocator_core.sv
